// ===== src/ptp_pkg.sv =====
`timescale 1ns / 1ps
package ptp_pkg;

  localparam int ENTRY_W    = 32;
  localparam int FIELD_W    = 32;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_LANES  = 3;

  localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
    logic                      w_zero;
    logic                      saturated;
  } ptp_res_t;

endpackage

// ===== src/ptp_if.sv =====
`timescale 1ns / 1ps
interface ptp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface ptp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic        w_zero;
  logic        saturated;
  modport source (output valid, output out_x, output out_y, output out_z,
                  output w_zero, output saturated, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input w_zero, input saturated, output ready);
endinterface

interface ptp_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/ptp_mac.sv =====
`timescale 1ns / 1ps
module ptp_mac #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32,
  parameter int SUM_W       = 66
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  input  logic signed [COORD_WIDTH-1:0] pz,
  input  logic [7:0][63:0]              mat,
  output logic                          sum_valid,
  output logic signed [SUM_W-1:0]       sum [4]
);
  import ptp_pkg::*;

  localparam int PW = ENTRY_W + COORD_WIDTH;
  localparam int TW = ENTRY_W + FRAC_BITS;

  logic                      v1_r, v2_r, v3_r;
  logic signed [PW-1:0]      prod_r [4][3];
  logic signed [TW-1:0]      trans_r [4];
  logic signed [SUM_W-1:0]   pa_r [4];
  logic signed [SUM_W-1:0]   pb_r [4];
  logic signed [SUM_W-1:0]   sum_r [4];
  logic signed [COORD_WIDTH-1:0] p [3];

  assign p[0] = px;
  assign p[1] = py;
  assign p[2] = pz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_r[r][c] <= $signed(mat[r*2 + c/2][(c%2)*ENTRY_W +: ENTRY_W]) * p[c];
        end
        trans_r[r] <= {mat[r*2 + 1][ENTRY_W +: ENTRY_W], {FRAC_BITS{1'b0}}};
        pa_r[r]    <= SUM_W'(prod_r[r][0]) + SUM_W'(prod_r[r][1]);
        pb_r[r]    <= SUM_W'(prod_r[r][2]) + SUM_W'(trans_r[r]);
        sum_r[r]   <= pa_r[r] + pb_r[r];
      end
    end
  end

  assign sum_valid = v3_r;
  assign sum       = sum_r;

endmodule

// ===== src/ptp_div.sv =====
`timescale 1ns / 1ps
module ptp_div #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32,
  parameter int SUM_W       = 66
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    sum_valid,
  input  logic signed [SUM_W-1:0] sum [4],
  output logic                    res_valid,
  output ptp_pkg::ptp_res_t       res
);
  import ptp_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = SUM_W + FRAC_BITS;
  localparam int XW = ((NW > SUM_W + CW) ? NW : SUM_W + CW) + 1;

  logic                 a_v_r, a_wz_r;
  logic [2:0]           a_neg_r;
  logic [SUM_W-1:0]     a_nm_r [3];
  logic [SUM_W-1:0]     a_dm_r;

  logic                 v_s   [CW+1];
  logic                 wz_s  [CW+1];
  logic [2:0]           neg_s [CW+1];
  logic [2:0]           ovf_s [CW+1];
  logic [SUM_W-1:0]     dm_s  [CW+1];
  logic [NW-1:0]        rem_s [CW+1][3];
  logic [CW-1:0]        q_s   [CW+1][3];

  logic                 fin_v_r;
  ptp_res_t             fin_r;
  ptp_res_t             fin_nxt;
  logic [CW-1:0]        lim [3];
  logic [CW-1:0]        mag [3];
  logic [CW-1:0]        val [3];
  logic [2:0]           sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      v_s[0]  <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (ce) begin
      a_v_r   <= sum_valid;
      v_s[0]  <= a_v_r;
      fin_v_r <= v_s[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a_wz_r <= (sum[3] == '0);
      a_dm_r <= sum[3][SUM_W-1] ? SUM_W'(-sum[3]) : SUM_W'(sum[3]);
      for (int k = 0; k < NUM_LANES; k++) begin
        a_neg_r[k] <= sum[k][SUM_W-1] ^ sum[3][SUM_W-1];
        a_nm_r[k]  <= sum[k][SUM_W-1] ? SUM_W'(-sum[k]) : SUM_W'(sum[k]);
      end
      wz_s[0]  <= a_wz_r;
      neg_s[0] <= a_neg_r;
      dm_s[0]  <= a_dm_r;
      for (int k = 0; k < NUM_LANES; k++) begin
        rem_s[0][k] <= {a_nm_r[k], {FRAC_BITS{1'b0}}};
        q_s[0][k]   <= '0;
        ovf_s[0][k] <= XW'({a_nm_r[k], {FRAC_BITS{1'b0}}}) >= (XW'(a_dm_r) << CW);
      end
      fin_r <= fin_nxt;
    end
  end

  for (genvar j = 0; j < CW; j++) begin : g_bit
    localparam int SH = CW - 1 - j;
    logic [NW-1:0] rn [3];
    logic [CW-1:0] qn [3];

    always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
        if (XW'(rem_s[j][k]) >= (XW'(dm_s[j]) << SH)) begin
          rn[k] = NW'(XW'(rem_s[j][k]) - (XW'(dm_s[j]) << SH));
          qn[k] = q_s[j][k] | (CW'(1) << SH);
        end else begin
          rn[k] = rem_s[j][k];
          qn[k] = q_s[j][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s[j+1] <= 1'b0;
      end else if (ce) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        wz_s[j+1]  <= wz_s[j];
        neg_s[j+1] <= neg_s[j];
        ovf_s[j+1] <= ovf_s[j];
        dm_s[j+1]  <= dm_s[j];
        rem_s[j+1] <= rn;
        q_s[j+1]   <= qn;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      lim[k] = neg_s[CW][k] ? (CW'(1) << (CW-1)) : ((CW'(1) << (CW-1)) - CW'(1));
      sat[k] = ovf_s[CW][k] | (q_s[CW][k] > lim[k]);
      mag[k] = sat[k] ? lim[k] : q_s[CW][k];
      val[k] = neg_s[CW][k] ? CW'(-mag[k]) : mag[k];
    end
    if (wz_s[CW]) begin
      fin_nxt.x         = '0;
      fin_nxt.y         = '0;
      fin_nxt.z         = '0;
      fin_nxt.w_zero    = 1'b1;
      fin_nxt.saturated = 1'b0;
    end else begin
      fin_nxt.x         = FIELD_W'($signed(val[0]));
      fin_nxt.y         = FIELD_W'($signed(val[1]));
      fin_nxt.z         = FIELD_W'($signed(val[2]));
      fin_nxt.w_zero    = 1'b0;
      fin_nxt.saturated = |sat;
    end
  end

  assign res_valid = fin_v_r;
  assign res       = fin_r;

endmodule

// ===== src/point_transform_perspective.sv =====
`timescale 1ns / 1ps
// Throughput: one word per cycle while the skid stage is empty (input ready high);
// three multiply and sum stages, then one quotient bit per stage.
// The output register has a one-word skid stage, so input ready is a registered signal.
// Reset is synchronous and active low; it clears the valid bits and loads the identity matrix.
module point_transform_perspective #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ptp_in_if.sink      in_ch,
  ptp_out_if.source   out_ch,
  ptp_cfg_if.sink     cfg_ch
);
  import ptp_pkg::*;

  localparam int SUM_W = ((COORD_WIDTH > FRAC_BITS) ? ENTRY_W + COORD_WIDTH
                                                    : ENTRY_W + FRAC_BITS) + 2;
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  logic [7:0][63:0]        mat_r;
  logic [7:0][63:0]        mat_rst;
  logic                    ce;
  logic                    sum_valid;
  logic signed [SUM_W-1:0] sum [4];
  logic                    fin_v;
  ptp_res_t                fin;
  logic                    ov_r, sv_r, pop;
  ptp_res_t                out_r, sk_r;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    mat_rst                  = '0;
    mat_rst[REG_ROW0_COLS01] = ONE;
    mat_rst[REG_ROW1_COLS01] = ONE << 32;
    mat_rst[REG_ROW2_COLS23] = ONE;
    mat_rst[REG_ROW3_COLS23] = ONE << 32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= mat_rst;
    end else if (cfg_ch.valid && (cfg_ch.index < CFG_IDX_W'(NUM_REGS))) begin
      mat_r[cfg_ch.index[REG_IDX_W-1:0]] <= cfg_ch.data;
    end
  end

  assign ce          = !sv_r;
  assign in_ch.ready = ce;

  ptp_mac #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUM_W(SUM_W)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (in_ch.valid),
    .px        ($signed(in_ch.in_x[COORD_WIDTH-1:0])),
    .py        ($signed(in_ch.in_y[COORD_WIDTH-1:0])),
    .pz        ($signed(in_ch.in_z[COORD_WIDTH-1:0])),
    .mat       (mat_r),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  ptp_div #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH), .SUM_W(SUM_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .sum_valid (sum_valid),
    .sum       (sum),
    .res_valid (fin_v),
    .res       (fin)
  );

  assign pop = ov_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else if (sv_r) begin
      if (pop) begin
        sv_r <= 1'b0;
      end
    end else if (!ov_r || pop) begin
      ov_r <= fin_v;
    end else if (fin_v) begin
      sv_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sv_r) begin
      if (pop) begin
        out_r <= sk_r;
      end
    end else if (!ov_r || pop) begin
      out_r <= fin;
    end else if (fin_v) begin
      sk_r <= fin;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.out_x     = out_r.x;
  assign out_ch.out_y     = out_r.y;
  assign out_ch.out_z     = out_r.z;
  assign out_ch.w_zero    = out_r.w_zero;
  assign out_ch.saturated = out_r.saturated;

endmodule

// ===== src/ptp_chk.sv =====
`timescale 1ns / 1ps
module ptp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        w_zero,
  input logic        saturated,
  input logic        cfg_ready
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid straight after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && w_zero |-> out_x == 32'd0 && out_y == 32'd0 && out_z == 32'd0 && !saturated)
    else $error("zero w word carries non-zero fields");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while no result word is waiting");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(w_zero))
    else $error("stalled result word changed");

endmodule

bind point_transform_perspective ptp_chk u_ptp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_x     (out_ch.out_x),
  .out_y     (out_ch.out_y),
  .out_z     (out_ch.out_z),
  .w_zero    (out_ch.w_zero),
  .saturated (out_ch.saturated),
  .cfg_ready (cfg_ch.ready)
);

// ===== dv/tb_point_transform_perspective.sv =====
`timescale 1ns / 1ps
module tb_point_transform_perspective;
  import ptp_pkg::*;

  localparam int FRAC = 16;
  localparam int LATENCY = 38;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [7:0] REG_ROW0_COLS23 = 8'd1;
  localparam logic [7:0] REG_ROW1_COLS23 = 8'd3;
  localparam logic [7:0] REG_ROW2_COLS01 = 8'd4;
  localparam logic [7:0] REG_ROW3_COLS01 = 8'd6;

  class projection_scoreboard;
    logic [63:0] matrix [8];
    ptp_res_t pending [$];
    int mismatches;
    int words_checked;

    function void reset_matrix();
      foreach (matrix[i]) matrix[i] = '0;
      matrix[REG_ROW0_COLS01] = 64'd1 << FRAC;
      matrix[REG_ROW1_COLS01] = 64'd1 << (FRAC + 32);
      matrix[REG_ROW2_COLS23] = 64'd1 << FRAC;
      matrix[REG_ROW3_COLS23] = 64'd1 << (FRAC + 32);
    endfunction

    function logic signed [127:0] row_dot(int row, logic signed [31:0] p [3]);
      logic signed [127:0] acc;
      logic signed [31:0] e;
      logic [63:0] r;
      r = matrix[row * 2 + 1];
      e = r[63:32];
      acc = 128'(e) <<< FRAC;
      for (int c = 0; c < 3; c++) begin
        r = matrix[row * 2 + c / 2];
        e = (c % 2) ? r[63:32] : r[31:0];
        acc += 128'(e) * 128'(p[c]);
      end
      return acc;
    endfunction

    function logic [31:0] quotient(logic signed [127:0] num, logic signed [127:0] den,
                                   inout logic sat);
      logic neg;
      logic [127:0] n, d, q, lim;
      neg = num[127] ^ den[127];
      n = num[127] ? -num : num;
      d = den[127] ? -den : den;
      n = n << FRAC;
      q = n / d;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        q = lim;
        sat = 1'b1;
      end
      return neg ? -q[31:0] : q[31:0];
    endfunction

    function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      logic signed [31:0] p [3];
      logic signed [127:0] w;
      ptp_res_t res;
      p[0] = x;
      p[1] = y;
      p[2] = z;
      res = '0;
      w = row_dot(3, p);
      if (w == 0) begin
        res.w_zero = 1'b1;
      end else begin
        res.x = quotient(row_dot(0, p), w, res.saturated);
        res.y = quotient(row_dot(1, p), w, res.saturated);
        res.z = quotient(row_dot(2, p), w, res.saturated);
      end
      pending.push_back(res);
    endfunction

    function void check_word(ptp_res_t got);
      ptp_res_t exp;
      words_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got.x !== exp.x || got.y !== exp.y || got.z !== exp.z ||
          got.w_zero !== exp.w_zero || got.saturated !== exp.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Mismatch: expected x=%h y=%h z=%h wz=%b sat=%b, ",
                    "got x=%h y=%h z=%h wz=%b sat=%b"},
                   exp.x, exp.y, exp.z, exp.w_zero, exp.saturated,
                   got.x, got.y, got.z, got.w_zero, got.saturated);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  ptp_in_if in_ch ();
  ptp_out_if out_ch ();
  ptp_cfg_if cfg_ch ();
  projection_scoreboard sb;
  int idle_cycles;
  int settings_used;
  logic stim_done;

  point_transform_perspective dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.out_x, out_ch.out_y, out_ch.out_z, out_ch.w_zero, out_ch.saturated});
  end

  initial begin
    int g;
    forever begin
      @(posedge clk);
      g = gap_length();
      if (g == 0 || $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(logic [7:0] idx, logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < 8) sb.matrix[idx] = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x <= x;
    in_ch.in_y <= y;
    in_ch.in_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(x, y, z);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic logic [31:0] rand_entry(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      default: return $urandom_range(0, 3) == 0 ? 32'h0 :
                        32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
    endcase
  endfunction

  task automatic load_matrix(int mode);
    logic [7:0] order [8];
    for (int i = 0; i < 8; i++) order[i] = 8'(i);
    order.shuffle();
    for (int i = 0; i < 8; i++)
      write_reg(order[i], {rand_entry(mode), rand_entry(mode)});
    settings_used++;
  endtask

  initial begin
    stim_done = 1'b0;
    sb = new();
    sb.reset_matrix();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Identity matrix: coordinate extremes and zero pass straight through.
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h0000_0001);
    drain();

    // W row depends on z only: z of zero gives a zero w.
    write_reg(REG_ROW3_COLS01, 64'h0);
    write_reg(8'(REG_ROW3_COLS23), {32'h0, 32'h0001_0000});
    write_reg(REG_ROW0_COLS23, {32'h7fff_ffff, 32'h0});
    write_reg(REG_ROW1_COLS23, {32'h8000_0000, 32'h0});
    write_reg(REG_ROW2_COLS01, {32'hffff_ffff, 32'h0000_0001});
    write_reg(8'd9, 64'hdead_beef_0000_0001);
    write_reg(8'hff, 64'h0);
    send_point(32'h1234_5678, 32'h0, 32'h0);
    send_point(32'h0001_0000, 32'h0002_0000, 32'h0000_0001);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h0, 32'h0, 32'h0001_0000);
    drain();

    // All-ones and extreme entries.
    for (int i = 0; i < 8; i++) write_reg(8'(i), 64'hffff_ffff_ffff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555);
    send_point(32'haaaa_aaaa, 32'h0, 32'h1);
    drain();
    for (int i = 0; i < 8; i++) write_reg(8'(i), 64'h8000_0000_7fff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h5555_5555);
    send_point(32'h0, 32'h0, 32'h0);
    drain();
    settings_used = 4;

    for (int phase = 0; phase < 11; phase++) begin
      load_matrix(phase % 3);
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(0, 19) == 0)
          send_point(rand_coord(), rand_coord(), 32'h0);
        else
          send_point(rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end
    write_reg(8'h80, 64'h0);
    stim_done = 1'b1;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results outstanding", sb.pending.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (stim_done && sb.pending.size() == 0 && !in_ch.valid && !cfg_ch.valid) begin
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d result words over %0d matrix settings.",
                 sb.words_checked, settings_used);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
          $display("Testbench completed without errors");
        end else begin
          $display("%0d mismatches", sb.mismatches);
          $display("Testbench completed WITH ERRORS");
        end
        $finish;
      end
    end
  end
endmodule
